>>> hdl/cpc_pkg.sv
// Shared constants and widths for the cell pedestal correction block.
`default_nettype none
package cpc_pkg;

	localparam int CELLS             = 1024;
	localparam int CHIPS             = 4;
	localparam int CHANNELS_PER_CHIP = 8;
	localparam int SAMPLE_BITS       = 12;

	localparam int NUM_CHANNELS = CHIPS * CHANNELS_PER_CHIP;

	// Port field widths.
	localparam int REQ_W   = 2;
	localparam int POS_W   = 10;
	localparam int CHAN_W  = 5;
	localparam int TRIG_W  = 10;
	localparam int RAW_W   = 12;
	localparam int PED_W   = 12;
	localparam int TIME_W  = 24;
	localparam int CORR_W  = 13;

	// Table geometry; CELLS and CHANNELS_PER_CHIP are powers of two.
	localparam int CELL_W     = $clog2(CELLS);
	localparam int CPC_W      = $clog2(CHANNELS_PER_CHIP);
	localparam int CHIP_W     = (CHIPS > 1) ? $clog2(CHIPS) : 1;
	localparam int PED_ADDR_W = CHAN_W + CELL_W;
	localparam int TIM_ADDR_W = CHIP_W + CELL_W;
	localparam int PED_DEPTH  = NUM_CHANNELS * CELLS;
	localparam int TIM_DEPTH  = CHIPS * CELLS;
	localparam int SUM_W      = TRIG_W + 1;
	localparam int DIFF_W     = RAW_W + 2;

	localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((1 << SAMPLE_BITS) - 1);
	localparam logic signed [DIFF_W-1:0] CORR_MAX = DIFF_W'((1 << (CORR_W - 1)) - 1);
	localparam logic signed [DIFF_W-1:0] CORR_MIN = -DIFF_W'(1 << (CORR_W - 1));

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_PED  = 2'd0,
		REQ_LOAD_TIME = 2'd1,
		REQ_CORRECT   = 2'd2,
		REQ_NONE      = 2'd3
	} req_t;

endpackage
`default_nettype wire

>>> hdl/cell_pedestal_correction.sv
// Cell pedestal correction: per-cell pedestal and time tables with a two-stage read path.
//
// Every word is taken in one cycle, so start may be held high continuously and busy
// stays low. A correct word gives its result on the valid strobe after the synchronous
// read of the pedestal and time memories at cell (trigger_cell + position) mod CELLS and
// then the subtraction and saturation into the output register. Load words in range
// write one table entry at the acceptance edge and give no result; a correct word
// accepted in the very next cycle already reads the new entry. Unused request codes
// are dropped. Entries that were never loaded read back as arbitrary data.
`default_nettype none
module cell_pedestal_correction (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [cpc_pkg::REQ_W-1:0]           req_type,
	input  wire logic [cpc_pkg::POS_W-1:0]           position,
	input  wire logic [cpc_pkg::CHAN_W-1:0]          channel,
	input  wire logic [cpc_pkg::TRIG_W-1:0]          trigger_cell,
	input  wire logic [cpc_pkg::RAW_W-1:0]           raw_sample,
	input  wire logic [cpc_pkg::PED_W-1:0]           pedestal_value,
	input  wire logic signed [cpc_pkg::TIME_W-1:0]   time_value,
	output logic                                     valid,
	output logic signed [cpc_pkg::CORR_W-1:0]        corrected_sample,
	output logic signed [cpc_pkg::TIME_W-1:0]        time_correction
);

	logic [cpc_pkg::PED_W-1:0]  ped_mem [cpc_pkg::PED_DEPTH];
	logic [cpc_pkg::TIME_W-1:0] tim_mem [cpc_pkg::TIM_DEPTH];

	logic                             accept;
	cpc_pkg::req_t                    req;
	logic                             in_range;
	logic [cpc_pkg::SUM_W-1:0]        cell_sum;
	logic [cpc_pkg::CELL_W-1:0]       cell_idx;
	logic [cpc_pkg::CHIP_W-1:0]       chip;
	logic [cpc_pkg::PED_ADDR_W-1:0]   ped_addr;
	logic [cpc_pkg::TIM_ADDR_W-1:0]   tim_addr;
	logic                             ped_we;
	logic                             tim_we;
	logic                             rd_en;

	logic                             valid_s1;
	logic                             in_range_s1;
	logic [cpc_pkg::RAW_W-1:0]        raw_s1;
	logic [cpc_pkg::PED_W-1:0]        ped_rd_s1;
	logic [cpc_pkg::TIME_W-1:0]       tim_rd_s1;

	logic signed [cpc_pkg::DIFF_W-1:0] diff;
	logic signed [cpc_pkg::CORR_W-1:0] diff_sat;

	logic                              valid_s2;
	logic signed [cpc_pkg::CORR_W-1:0] corr_s2;
	logic signed [cpc_pkg::TIME_W-1:0] time_s2;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign req    = cpc_pkg::req_t'(req_type);

	assign in_range = (32'(channel) < cpc_pkg::NUM_CHANNELS) &&
		(32'(position) < cpc_pkg::CELLS);

	assign cell_sum = cpc_pkg::SUM_W'(trigger_cell) + cpc_pkg::SUM_W'(position);
	assign chip     = cpc_pkg::CHIP_W'(channel >> cpc_pkg::CPC_W);

	// Loads address the table with the position itself; corrections with the rotated cell.
	always_comb begin
		if (req == cpc_pkg::REQ_CORRECT) begin
			cell_idx = cell_sum[cpc_pkg::CELL_W-1:0];
		end else begin
			cell_idx = position[cpc_pkg::CELL_W-1:0];
		end
	end

	assign ped_addr = {channel, cell_idx};
	assign tim_addr = {chip, cell_idx};

	assign ped_we = accept && in_range && (req == cpc_pkg::REQ_LOAD_PED);
	assign tim_we = accept && in_range && (req == cpc_pkg::REQ_LOAD_TIME);
	assign rd_en  = accept && (req == cpc_pkg::REQ_CORRECT);

	// One access per cycle per memory, so a load followed by a correct needs no bypass.
	always_ff @(posedge clk) begin
		if (ped_we) begin
			ped_mem[ped_addr] <= pedestal_value;
		end
		if (rd_en) begin
			ped_rd_s1 <= ped_mem[ped_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tim_we) begin
			tim_mem[tim_addr] <= time_value;
		end
		if (rd_en) begin
			tim_rd_s1 <= tim_mem[tim_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			in_range_s1 <= in_range;
			raw_s1      <= raw_sample & cpc_pkg::SAMPLE_MASK;
		end
	end

	always_comb begin
		diff = $signed({2'b00, raw_s1}) - $signed({2'b00, ped_rd_s1 & cpc_pkg::SAMPLE_MASK});
		if (diff > cpc_pkg::CORR_MAX) begin
			diff_sat = cpc_pkg::CORR_MAX[cpc_pkg::CORR_W-1:0];
		end else if (diff < cpc_pkg::CORR_MIN) begin
			diff_sat = cpc_pkg::CORR_MIN[cpc_pkg::CORR_W-1:0];
		end else begin
			diff_sat = diff[cpc_pkg::CORR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (in_range_s1) begin
				corr_s2 <= diff_sat;
				time_s2 <= $signed(tim_rd_s1);
			end else begin
				corr_s2 <= '0;
				time_s2 <= '0;
			end
		end
	end

	assign valid            = valid_s2;
	assign corrected_sample = corr_s2;
	assign time_correction  = time_s2;

endmodule
`default_nettype wire

>>> hdl/cpc_checker.sv
// Port-level checks for the cell pedestal correction block and their binding.
`default_nettype none
module cpc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic [cpc_pkg::REQ_W-1:0]          req_type,
	input wire logic                               valid,
	input wire logic signed [cpc_pkg::CORR_W-1:0]  corrected_sample
);

	logic correct_acc;
	logic other_acc;

	assign correct_acc = start && !busy && (req_type == cpc_pkg::REQ_CORRECT);
	assign other_acc   = !(start && !busy && (req_type == cpc_pkg::REQ_CORRECT));

	// Every correct word is followed by its result on valid.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		correct_acc |-> ##2 valid)
		else $error("correct word produced no result");

	// Cycles without an accepted correct word, loads and unused codes included, never produce a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		other_acc |-> ##2 !valid)
		else $error("result without a correct word");

	// A difference of two in-range samples never reaches the negative limit.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (corrected_sample != cpc_pkg::CORR_MIN[cpc_pkg::CORR_W-1:0]))
		else $error("corrected word outside sample range");

	// The block never holds off the source.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind cell_pedestal_correction cpc_checker u_cpc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.req_type         (req_type),
	.valid            (valid),
	.corrected_sample (corrected_sample)
);
`default_nettype wire

>>> tb/cell_pedestal_correction_test.sv
// Self-checking testbench for the cell pedestal correction block.
`default_nettype none
module cell_pedestal_correction_test;
	import cpc_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 320;

	typedef struct packed {
		logic signed [CORR_W-1:0] corr;
		logic signed [TIME_W-1:0] tcorr;
	} correction_t;

	// Mirrors the pedestal and time tables and holds the corrections still to come.
	class correction_book;
		logic [PED_W-1:0] pedestal_tab [PED_DEPTH];
		logic signed [TIME_W-1:0] time_tab [TIM_DEPTH];
		correction_t awaited[$];
		int errors;

		function void take_word(req_t req, logic [POS_W-1:0] pos, logic [CHAN_W-1:0] chan,
				logic [TRIG_W-1:0] trig, logic [RAW_W-1:0] raw, logic [PED_W-1:0] pedv,
				logic signed [TIME_W-1:0] timev);
			int chip;
			int cell_idx;
			int diff;
			bit in_range;
			correction_t c;
			chip = int'(chan) / CHANNELS_PER_CHIP;
			in_range = (int'(chan) < NUM_CHANNELS) && (int'(pos) < CELLS);
			case (req)
				REQ_LOAD_PED: if (in_range) pedestal_tab[int'(chan) * CELLS + int'(pos)] = pedv;
				REQ_LOAD_TIME: if (in_range) time_tab[chip * CELLS + int'(pos)] = timev;
				REQ_CORRECT: begin
					c = '0;
					if (in_range) begin
						// The sample position counts from the trigger cell and wraps around.
						cell_idx = (int'(trig) + int'(pos)) % CELLS;
						diff = int'(raw & SAMPLE_MASK)
							- int'(pedestal_tab[int'(chan) * CELLS + cell_idx] & SAMPLE_MASK);
						if (diff > 4095) diff = 4095;
						if (diff < -4096) diff = -4096;
						c.corr = CORR_W'(diff);
						c.tcorr = time_tab[chip * CELLS + cell_idx];
					end
					awaited.push_back(c);
				end
				default: ;
			endcase
		endfunction

		function void check_correction(logic signed [CORR_W-1:0] corr,
				logic signed [TIME_W-1:0] tcorr);
			correction_t c;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected word, corrected_sample %0d time_correction %0d",
					$time, corr, tcorr);
				errors++;
				return;
			end
			c = awaited.pop_front();
			if (corr !== c.corr) begin
				$display("%0t: corrected_sample expected %0d, got %0d", $time, c.corr, corr);
				errors++;
			end
			if (tcorr !== c.tcorr) begin
				$display("%0t: time_correction expected %0d, got %0d", $time, c.tcorr, tcorr);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [REQ_W-1:0] req_type = REQ_NONE;
	logic [POS_W-1:0] position = '0;
	logic [CHAN_W-1:0] channel = '0;
	logic [TRIG_W-1:0] trigger_cell = '0;
	logic [RAW_W-1:0] raw_sample = '0;
	logic [PED_W-1:0] pedestal_value = '0;
	logic signed [TIME_W-1:0] time_value = '0;
	logic valid;
	logic signed [CORR_W-1:0] corrected_sample;
	logic signed [TIME_W-1:0] time_correction;

	correction_book book = new();
	int idle_pct = 0;
	int cycles = 0;
	bit pedestal_loaded [PED_DEPTH];
	bit time_loaded [TIM_DEPTH];
	int loaded_keys[$];

	cell_pedestal_correction dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.position(position),
		.channel(channel),
		.trigger_cell(trigger_cell),
		.raw_sample(raw_sample),
		.pedestal_value(pedestal_value),
		.time_value(time_value),
		.valid(valid),
		.corrected_sample(corrected_sample),
		.time_correction(time_correction)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cell_pedestal_correction_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && valid)
			book.check_correction(corrected_sample, time_correction);
	end

	// Drives one word from a falling edge and returns at the falling edge after acceptance.
	task automatic send_word(input req_t req, input int pos, input int chan, input int trig,
			input int raw, input int pedv, input int timev);
		int key;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		position <= POS_W'(pos);
		channel <= CHAN_W'(chan);
		trigger_cell <= TRIG_W'(trig);
		raw_sample <= RAW_W'(raw);
		pedestal_value <= PED_W'(pedv);
		time_value <= TIME_W'(timev);
		@(posedge clk);
		while (busy) @(posedge clk);
		book.take_word(req, POS_W'(pos), CHAN_W'(chan), TRIG_W'(trig), RAW_W'(raw),
			PED_W'(pedv), TIME_W'(timev));
		if (req == REQ_LOAD_PED) begin
			key = chan * CELLS + pos;
			if (!pedestal_loaded[key]) loaded_keys.push_back(key);
			pedestal_loaded[key] = 1'b1;
		end else if (req == REQ_LOAD_TIME) begin
			time_loaded[(chan / CHANNELS_PER_CHIP) * CELLS + pos] = 1'b1;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (book.pending() != 0) @(negedge clk);
	endtask

	// Returns 1 when the word counts as work, 0 for an ignored request code.
	task automatic random_word(output bit counted);
		int r;
		int key;
		int chan;
		int cell_idx;
		int trig;
		r = $urandom_range(99);
		counted = 1'b1;
		if (r < 8) begin
			send_word(REQ_NONE, $urandom_range(1023), $urandom_range(31), $urandom_range(1023),
				$urandom_range(4095), $urandom_range(4095), int'($urandom()));
			counted = 1'b0;
		end else if (r < 30 || loaded_keys.size() == 0) begin
			// Half of the pedestal loads overwrite an entry that corrections already use.
			if (loaded_keys.size() != 0 && $urandom_range(1)) begin
				key = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
				chan = key / CELLS;
				cell_idx = key % CELLS;
			end else begin
				chan = $urandom_range(31);
				cell_idx = $urandom_range(1023);
			end
			send_word(REQ_LOAD_PED, cell_idx, chan, $urandom_range(1023), $urandom_range(4095),
				$urandom_range(4095), int'($urandom()));
		end else if (r < 40) begin
			send_word(REQ_LOAD_TIME, $urandom_range(1023), $urandom_range(31),
				$urandom_range(1023), $urandom_range(4095), $urandom_range(4095),
				int'($urandom()));
		end else begin
			key = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
			chan = key / CELLS;
			cell_idx = key % CELLS;
			if (!time_loaded[(chan / CHANNELS_PER_CHIP) * CELLS + cell_idx]) begin
				// The time entry of that cell is missing, so load it before any correction.
				send_word(REQ_LOAD_TIME, cell_idx, chan, $urandom_range(1023),
					$urandom_range(4095), $urandom_range(4095), int'($urandom()));
			end else begin
				trig = $urandom_range(1023);
				send_word(REQ_CORRECT, (cell_idx - trig + CELLS) % CELLS, chan, trig,
					$urandom_range(4095), $urandom_range(4095), int'($urandom()));
			end
		end
	endtask

	initial begin
		int pct [3];
		int count;
		bit counted;
		pct = '{27, 66, 0};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words, back to back.
		send_word(REQ_LOAD_PED, 0, 0, 0, 0, 0, 0);
		send_word(REQ_LOAD_TIME, 0, 0, 0, 0, 0, -8388608);
		send_word(REQ_CORRECT, 0, 0, 0, 4095, 0, 0);
		send_word(REQ_LOAD_PED, 1023, 31, 0, 0, 4095, 0);
		send_word(REQ_LOAD_TIME, 1023, 31, 0, 0, 0, 8388607);
		send_word(REQ_CORRECT, 0, 31, 1023, 0, 0, 0);
		send_word(REQ_LOAD_PED, 0, 31, 0, 0, 2048, 0);
		send_word(REQ_LOAD_TIME, 0, 24, 0, 0, 0, 0);
		send_word(REQ_CORRECT, 1, 31, 1023, 2048, 0, 0);
		send_word(REQ_CORRECT, 1023, 31, 1, 4095, 0, 0);
		send_word(REQ_CORRECT, 512, 31, 512, 1365, 0, 0);
		send_word(REQ_NONE, 1023, 31, 1023, 4095, 4095, -1);
		// A correction right after a load must already see the new entry.
		send_word(REQ_LOAD_PED, 0, 0, 0, 0, 1, 0);
		send_word(REQ_CORRECT, 0, 0, 0, 0, 0, 0);
		send_word(REQ_LOAD_TIME, 0, 7, 0, 0, 0, 256);
		send_word(REQ_CORRECT, 0, 0, 0, 2730, 0, 0);
		send_word(REQ_LOAD_PED, 0, 7, 0, 0, 4000, 0);
		send_word(REQ_CORRECT, 0, 7, 0, 2730, 0, 0);
		drain();

		foreach (pct[p]) begin
			idle_pct = pct[p];
			count = 0;
			while (count < PHASE_WORDS) begin
				random_word(counted);
				if (counted) count++;
				if (count == PHASE_WORDS / 2 && counted && $urandom_range(1)) drain();
			end
			drain();
		end

		repeat (6) @(negedge clk);
		if (book.errors == 0)
			$display("cell_pedestal_correction_test: done, clean");
		else
			$display("cell_pedestal_correction_test: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
hdl/cpc_pkg.sv
hdl/cell_pedestal_correction.sv
hdl/cpc_checker.sv
tb/cell_pedestal_correction_test.sv
